@@ rtl/rgbk_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbk_pkg
// Shared types, constants and register codes of the 3x3 RGB convolution core.
// ----------------------------------------------------------------------------
package rgbk_pkg;

    // Geometry and arithmetic sizes
    localparam int KERNEL_SIZE = 3;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COEF_BITS   = 16;
    localparam int COEF_SLOT   = 16;
    localparam int PIX_W       = 8;
    localparam int PROD_W      = COEF_BITS + PIX_W + 1;
    localparam int SUM_W       = 28;
    localparam int MAG_W       = SUM_W - 1;
    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = $clog2(MAG_W);
    localparam int MAC_CNT_W   = $clog2(TAPS + 1);
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;

    localparam logic [WIDTH_W-1:0]  MIN_DIM_W  = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  MAX_DIM_W  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_DIM_H  = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] MAX_DIM_H  = HEIGHT_W'(4096);
    localparam logic [PIX_W-1:0]    PIX_MAX    = PIX_W'(255);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd5;

    typedef struct packed {
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] red_in;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_column;
        logic             frame_done;
    } pix_out_t;

    // Partial sums of the three planes passed along the cell chain
    typedef struct packed {
        logic signed [SUM_W-1:0] red;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] blue;
    } sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

@@ rtl/rgbk_cell.sv @@
// ----------------------------------------------------------------------------
// rgbk_cell
// One window tap: holds an RGB sample, hands it to its left neighbor on a
// shift, and adds its weighted sample to the partial sums of the chain.
// ----------------------------------------------------------------------------
module rgbk_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                shift_en,
    input  logic [3*rgbk_pkg::PIX_W-1:0]        pix_in,
    output logic [3*rgbk_pkg::PIX_W-1:0]        pix_out,
    input  logic [rgbk_pkg::COEF_BITS-1:0]      coef,
    input  rgbk_pkg::sums_t                     sum_in,
    output rgbk_pkg::sums_t                     sum_out
);

    logic [3*rgbk_pkg::PIX_W-1:0]     pix_reg;
    rgbk_pkg::sums_t                  sum_reg;
    rgbk_pkg::sums_t                  sum_next;
    logic signed [rgbk_pkg::PROD_W-1:0] prod_r;
    logic signed [rgbk_pkg::PROD_W-1:0] prod_g;
    logic signed [rgbk_pkg::PROD_W-1:0] prod_b;

    // Hold the tap sample, load from the right neighbor on a shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    // Weight each plane and extend the running sums
    always_comb begin
        prod_r = $signed(coef) * $signed({1'b0, pix_reg[rgbk_pkg::PIX_W-1:0]});
        prod_g = $signed(coef) * $signed({1'b0, pix_reg[2*rgbk_pkg::PIX_W-1:rgbk_pkg::PIX_W]});
        prod_b = $signed(coef) *
                 $signed({1'b0, pix_reg[3*rgbk_pkg::PIX_W-1:2*rgbk_pkg::PIX_W]});
        sum_next.red   = sum_in.red +
            {{(rgbk_pkg::SUM_W-rgbk_pkg::PROD_W){prod_r[rgbk_pkg::PROD_W-1]}}, prod_r};
        sum_next.green = sum_in.green +
            {{(rgbk_pkg::SUM_W-rgbk_pkg::PROD_W){prod_g[rgbk_pkg::PROD_W-1]}}, prod_g};
        sum_next.blue  = sum_in.blue +
            {{(rgbk_pkg::SUM_W-rgbk_pkg::PROD_W){prod_b[rgbk_pkg::PROD_W-1]}}, prod_b};
    end

    // Register the partial sums toward the next cell
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign pix_out = pix_reg;
    assign sum_out = sum_reg;

endmodule

@@ rtl/rgbk_div.sv @@
// ----------------------------------------------------------------------------
// rgbk_div
// Radix-2 restoring divider for one plane: divides the weighted sum by the
// divisor toward zero, one quotient bit per cycle, then clamps to 0..255.
// ----------------------------------------------------------------------------
module rgbk_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [rgbk_pkg::SUM_W-1:0]     dividend,
    input  logic [rgbk_pkg::DIV_W-1:0]            divisor,
    output logic                                  done,
    output logic [rgbk_pkg::PIX_W-1:0]            result
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rgbk_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                             neg_reg, neg_next;
    logic [rgbk_pkg::DIV_W:0]         rem_reg, rem_next;
    logic [rgbk_pkg::MAG_W-1:0]       quo_reg, quo_next;
    logic [rgbk_pkg::DIV_W-1:0]       div_eff;
    logic [rgbk_pkg::DIV_W:0]         rem_shift;
    logic [rgbk_pkg::SUM_W-1:0]       mag;

    // Zero divisor acts as one
    assign div_eff = (divisor == '0) ? rgbk_pkg::DIV_W'(1) : divisor;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mag       = dividend[rgbk_pkg::SUM_W-1] ? -dividend : dividend;
        rem_shift = {rem_reg[rgbk_pkg::DIV_W-1:0], quo_reg[rgbk_pkg::MAG_W-1]};
        if (start) begin
            // Load the magnitude, remember the sign
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[rgbk_pkg::SUM_W-1];
            rem_next  = '0;
            quo_next  = mag[rgbk_pkg::MAG_W-1:0];
        end else if (busy_reg) begin
            // Shift in one dividend bit, subtract when it fits
            if (rem_shift >= {1'b0, div_eff}) begin
                rem_next = rem_shift - {1'b0, div_eff};
                quo_next = {quo_reg[rgbk_pkg::MAG_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[rgbk_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rgbk_pkg::DIV_CNT_W'(rgbk_pkg::MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Clamp: negative quotients go to zero, large ones saturate
    always_comb begin
        if (neg_reg) begin
            result = '0;
        end else if (|quo_reg[rgbk_pkg::MAG_W-1:rgbk_pkg::PIX_W]) begin
            result = rgbk_pkg::PIX_MAX;
        end else begin
            result = quo_reg[rgbk_pkg::PIX_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/rgb_kernel_convolution_core.sv @@
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_core
// 3x3 RGB convolution with signed coefficients, divisor and clamp.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_ channel (valid/ready) and filtered
// interior pixels leave on the m_ channel with their centre row and column;
// border pixels give no transfer on m_. frame_done marks the last interior
// pixel of a frame. Registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the core is idle, which the core does not enforce.
// One pixel is handled at a time. A border pixel goes through a memory read,
// then the window and line store update. An interior pixel does the same and
// then passes the chain of nine multiply-add cells, the bit-serial dividers
// (one quotient bit per cycle over 27 bits) and the output register.
// The output register lets the next pixel be accepted while a result waits;
// a stalled receiver holds the core only when a second result is ready.
// Reset clears the counters, the window and the control state and loads the
// default registers (identity kernel, divisor 1, 1024x768). The line stores
// are not cleared; entries are written before any result uses them.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rgbk_pkg::pix_in_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rgbk_pkg::pix_out_t                m_data,
    input  logic                              cfg_we,
    input  logic [rgbk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbk_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int PW = 3 * rgbk_pkg::PIX_W;

    // Configuration registers
    logic [rgbk_pkg::CFG_W-1:0]    coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [rgbk_pkg::DIV_W-1:0]    divisor_reg;
    logic [rgbk_pkg::WIDTH_W-1:0]  width_reg;
    logic [rgbk_pkg::HEIGHT_W-1:0] height_reg;
    logic [rgbk_pkg::WIDTH_W-1:0]  w_eff;
    logic [rgbk_pkg::HEIGHT_W-1:0] h_eff;

    // Control
    rgbk_pkg::state_t              state_reg, state_next;
    logic [rgbk_pkg::MAC_CNT_W-1:0] mac_cnt_reg, mac_cnt_next;
    logic [rgbk_pkg::COL_W-1:0]    col_reg, col_next;
    logic [rgbk_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [rgbk_pkg::WIDTH_W-1:0]  col_inc;
    logic [rgbk_pkg::HEIGHT_W-1:0] row_inc;
    logic                          interior;
    logic                          last_pix;
    logic                          s_fire;
    logic                          shift_en;
    logic                          div_start;
    logic                          out_load;
    logic                          out_free;

    // Line stores and pixel data
    logic [PW-1:0]                 line1_mem [rgbk_pkg::MAX_WIDTH];
    logic [PW-1:0]                 line2_mem [rgbk_pkg::MAX_WIDTH];
    logic [PW-1:0]                 prev1_reg, prev2_reg;
    logic [PW-1:0]                 pix_reg;
    logic [rgbk_pkg::ADDR_W-1:0]   addr;

    // Result metadata and output register
    logic [rgbk_pkg::ROW_W-1:0]    meta_row_reg;
    logic [rgbk_pkg::COL_W-1:0]    meta_col_reg;
    logic                          meta_done_reg;
    logic                          m_valid_reg, m_valid_next;
    rgbk_pkg::pix_out_t            m_data_reg;

    // Cell chain
    logic [PW-1:0]                 tap [rgbk_pkg::TAPS];
    rgbk_pkg::sums_t               psum [rgbk_pkg::TAPS + 1];
    logic [rgbk_pkg::CFG_W-1:0]    coef_rows [rgbk_pkg::KERNEL_SIZE];
    logic                          div_done_r, div_done_g, div_done_b;
    logic [rgbk_pkg::PIX_W-1:0]    res_r, res_g, res_b;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= '0;
            coef_mid_reg <= rgbk_pkg::CFG_W'(48'h10000);
            coef_bot_reg <= '0;
            divisor_reg  <= rgbk_pkg::DIV_W'(1);
            width_reg    <= rgbk_pkg::WIDTH_W'(1024);
            height_reg   <= rgbk_pkg::HEIGHT_W'(768);
        end else if (cfg_we) begin
            case (cfg_index)
                rgbk_pkg::REG_COEF_TOP:    coef_top_reg <= cfg_wdata;
                rgbk_pkg::REG_COEF_MIDDLE: coef_mid_reg <= cfg_wdata;
                rgbk_pkg::REG_COEF_BOTTOM: coef_bot_reg <= cfg_wdata;
                rgbk_pkg::REG_DIVISOR:     divisor_reg  <= cfg_wdata[rgbk_pkg::DIV_W-1:0];
                rgbk_pkg::REG_WIDTH:       width_reg    <= cfg_wdata[rgbk_pkg::WIDTH_W-1:0];
                rgbk_pkg::REG_HEIGHT:      height_reg   <= cfg_wdata[rgbk_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb begin
        if (width_reg < rgbk_pkg::MIN_DIM_W) begin
            w_eff = rgbk_pkg::MIN_DIM_W;
        end else if (width_reg > rgbk_pkg::MAX_DIM_W) begin
            w_eff = rgbk_pkg::MAX_DIM_W;
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < rgbk_pkg::MIN_DIM_H) begin
            h_eff = rgbk_pkg::MIN_DIM_H;
        end else if (height_reg > rgbk_pkg::MAX_DIM_H) begin
            h_eff = rgbk_pkg::MAX_DIM_H;
        end else begin
            h_eff = height_reg;
        end
    end

    // Raster position bookkeeping
    always_comb begin
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        interior = (row_reg >= rgbk_pkg::ROW_W'(2)) && (col_reg >= rgbk_pkg::COL_W'(2));
        last_pix = ({1'b0, row_reg} == h_eff - 1'b1) && ({1'b0, col_reg} == w_eff - 1'b1);
        col_next = col_reg;
        row_next = row_reg;
        if (shift_en) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[rgbk_pkg::ROW_W-1:0];
            end else begin
                col_next = col_inc[rgbk_pkg::COL_W-1:0];
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign addr     = col_reg[rgbk_pkg::ADDR_W-1:0];

    // Next state
    always_comb begin
        state_next   = state_reg;
        mac_cnt_next = mac_cnt_reg;
        case (state_reg)
            rgbk_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rgbk_pkg::ST_LOAD;
                end
            end
            rgbk_pkg::ST_LOAD: begin
                mac_cnt_next = '0;
                state_next   = interior ? rgbk_pkg::ST_MAC : rgbk_pkg::ST_IDLE;
            end
            rgbk_pkg::ST_MAC: begin
                mac_cnt_next = mac_cnt_reg + 1'b1;
                if (mac_cnt_reg == rgbk_pkg::MAC_CNT_W'(rgbk_pkg::TAPS)) begin
                    state_next = rgbk_pkg::ST_DIV;
                end
            end
            rgbk_pkg::ST_DIV: begin
                if (div_done_r) begin
                    state_next = rgbk_pkg::ST_OUT;
                end
            end
            rgbk_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = rgbk_pkg::ST_IDLE;
                end
            end
            default: state_next = rgbk_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready   = (state_reg == rgbk_pkg::ST_IDLE);
        shift_en  = (state_reg == rgbk_pkg::ST_LOAD);
        div_start = (state_reg == rgbk_pkg::ST_MAC) &&
                    (mac_cnt_reg == rgbk_pkg::MAC_CNT_W'(rgbk_pkg::TAPS));
        out_load  = (state_reg == rgbk_pkg::ST_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rgbk_pkg::ST_IDLE;
            mac_cnt_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            mac_cnt_reg <= mac_cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // Read both line stores on a transfer, write them back in the next cycle
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prev1_reg <= line1_mem[addr];
            prev2_reg <= line2_mem[addr];
            pix_reg   <= {s_data.blue_in, s_data.green_in, s_data.red_in};
        end
        if (shift_en) begin
            line1_mem[addr] <= pix_reg;
            line2_mem[addr] <= prev1_reg;
        end
    end

    // Capture the centre position on every line store update, for use by an interior pixel
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            meta_row_reg  <= row_reg - 1'b1;
            meta_col_reg  <= col_reg - 1'b1;
            meta_done_reg <= last_pix;
        end
    end

    // Chain of window cells, top-left first
    assign coef_rows[0] = coef_top_reg;
    assign coef_rows[1] = coef_mid_reg;
    assign coef_rows[2] = coef_bot_reg;
    assign psum[0]      = '0;

    for (genvar r = 0; r < rgbk_pkg::KERNEL_SIZE; r++) begin : g_row
        for (genvar c = 0; c < rgbk_pkg::KERNEL_SIZE; c++) begin : g_col
            logic [PW-1:0] shift_in;
            if (c == rgbk_pkg::KERNEL_SIZE - 1) begin : g_edge
                if (r == 0) begin : g_top
                    assign shift_in = prev2_reg;
                end else if (r == 1) begin : g_mid
                    assign shift_in = prev1_reg;
                end else begin : g_bot
                    assign shift_in = pix_reg;
                end
            end else begin : g_inner
                assign shift_in = tap[r*rgbk_pkg::KERNEL_SIZE + c + 1];
            end
            rgbk_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .pix_in   (shift_in),
                .pix_out  (tap[r*rgbk_pkg::KERNEL_SIZE + c]),
                .coef     (coef_rows[r][c*rgbk_pkg::COEF_SLOT +: rgbk_pkg::COEF_BITS]),
                .sum_in   (psum[r*rgbk_pkg::KERNEL_SIZE + c]),
                .sum_out  (psum[r*rgbk_pkg::KERNEL_SIZE + c + 1])
            );
        end
    end

    // One divider per plane, run in lockstep
    rgbk_div u_div_r (
        .aclk (aclk), .aresetn (aresetn), .start (div_start),
        .dividend (psum[rgbk_pkg::TAPS].red), .divisor (divisor_reg),
        .done (div_done_r), .result (res_r)
    );
    rgbk_div u_div_g (
        .aclk (aclk), .aresetn (aresetn), .start (div_start),
        .dividend (psum[rgbk_pkg::TAPS].green), .divisor (divisor_reg),
        .done (div_done_g), .result (res_g)
    );
    rgbk_div u_div_b (
        .aclk (aclk), .aresetn (aresetn), .start (div_start),
        .dividend (psum[rgbk_pkg::TAPS].blue), .divisor (divisor_reg),
        .done (div_done_b), .result (res_b)
    );

    // Output register: load a finished result, drop valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.red_out       <= res_r;
            m_data_reg.green_out     <= res_g;
            m_data_reg.blue_out      <= res_b;
            m_data_reg.centre_row    <= meta_row_reg;
            m_data_reg.centre_column <= meta_col_reg;
            m_data_reg.frame_done    <= meta_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A transfer in always moves to the line store update
    a_fire_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == rgbk_pkg::ST_LOAD))
        else $error("transfer in not followed by line store update");

    // The three plane dividers finish together and only while waiting on them
    a_div_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done_r |-> (div_done_g && div_done_b && state_reg == rgbk_pkg::ST_DIV))
        else $error("plane dividers out of step");

    // A result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overrun");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 RGB convolution core.
// ----------------------------------------------------------------------------
// Streams raster pixels through the core under several kernels, divisors and
// image sizes, including out-of-range sizes and size changes in mid-frame.
// A behavioral convolver predicts every interior pixel. Each result transfer
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1600;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 5000;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    rgbk_pkg::pix_in_t                     s_data;
    logic                                  m_valid;
    logic                                  m_ready;
    rgbk_pkg::pix_out_t                    m_data;
    logic                                  cfg_we;
    logic [rgbk_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [rgbk_pkg::CFG_W-1:0]            cfg_wdata;

    // Pixels waiting to be sent and results waiting to be seen
    rgbk_pkg::pix_in_t  pending_pixels[$];
    rgbk_pkg::pix_out_t expected_pixels[$];

    // Mirror of the core's registers and state
    logic [rgbk_pkg::CFG_W-1:0]    kern_top, kern_mid, kern_bot;
    logic [rgbk_pkg::DIV_W-1:0]    div_reg;
    logic [rgbk_pkg::WIDTH_W-1:0]  width_reg;
    logic [rgbk_pkg::HEIGHT_W-1:0] height_reg;
    logic [23:0]                   lines[2*rgbk_pkg::MAX_WIDTH];
    logic [23:0]                   win[3][3];
    logic [rgbk_pkg::COL_W-1:0]    col_pos;
    logic [rgbk_pkg::ROW_W-1:0]    row_pos;

    int idle_send_pct;
    int idle_recv_pct;
    int mismatches;
    int idle_cycles;
    int pixels_sent;

    rgb_kernel_convolution_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_width();
        if (width_reg < 3) return 3;
        if (width_reg > rgbk_pkg::MAX_WIDTH) return rgbk_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int eff_height();
        if (height_reg < 3) return 3;
        if (height_reg > 4096) return 4096;
        return height_reg;
    endfunction

    // Weighted sum of one plane, divided, truncated toward zero and clamped
    function automatic logic [7:0] filter_plane(int shift);
        logic [rgbk_pkg::CFG_W-1:0] rows[3];
        longint acc;
        longint dv;
        rows[0] = kern_top;
        rows[1] = kern_mid;
        rows[2] = kern_bot;
        acc = 0;
        dv = (div_reg == 0) ? 1 : longint'(div_reg);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                acc += longint'($signed(rows[i][16*j +: 16])) *
                       longint'((win[i][j] >> shift) & 8'hFF);
        acc = acc / dv;
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return acc[7:0];
    endfunction

    // Advance the window and line stores by one pixel; queue any result
    task automatic convolve_pixel(rgbk_pkg::pix_in_t px);
        int w, h, c, r, addr;
        logic [23:0] prev1, prev2;
        rgbk_pkg::pix_out_t res;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        addr = c % rgbk_pkg::MAX_WIDTH;
        prev1 = lines[addr];
        prev2 = lines[rgbk_pkg::MAX_WIDTH + addr];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = prev2;
        win[1][2] = prev1;
        win[2][2] = {px.blue_in, px.green_in, px.red_in};
        lines[rgbk_pkg::MAX_WIDTH + addr] = prev1;
        lines[addr] = win[2][2];
        if (r >= 2 && c >= 2) begin
            res.red_out       = filter_plane(0);
            res.green_out     = filter_plane(8);
            res.blue_out      = filter_plane(16);
            res.centre_row    = rgbk_pkg::ROW_W'(r - 1);
            res.centre_column = rgbk_pkg::COL_W'(c - 1);
            res.frame_done    = (r == h - 1 && c == w - 1);
            expected_pixels.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = rgbk_pkg::COL_W'(c);
        row_pos = rgbk_pkg::ROW_W'(r);
    endtask

    // Write one register and keep the mirror in step
    task automatic write_reg(logic [rgbk_pkg::CFG_IDX_W-1:0] idx,
                             logic [rgbk_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            rgbk_pkg::REG_COEF_TOP:    kern_top   = val;
            rgbk_pkg::REG_COEF_MIDDLE: kern_mid   = val;
            rgbk_pkg::REG_COEF_BOTTOM: kern_bot   = val;
            rgbk_pkg::REG_DIVISOR:     div_reg    = val[rgbk_pkg::DIV_W-1:0];
            rgbk_pkg::REG_WIDTH:       width_reg  = val[rgbk_pkg::WIDTH_W-1:0];
            rgbk_pkg::REG_HEIGHT:      height_reg = val[rgbk_pkg::HEIGHT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [rgbk_pkg::CFG_W-1:0] t, logic [rgbk_pkg::CFG_W-1:0] m,
                             logic [rgbk_pkg::CFG_W-1:0] b, int dv, int w, int h);
        write_reg(rgbk_pkg::REG_COEF_TOP, t);
        write_reg(rgbk_pkg::REG_COEF_MIDDLE, m);
        write_reg(rgbk_pkg::REG_COEF_BOTTOM, b);
        write_reg(rgbk_pkg::REG_DIVISOR, rgbk_pkg::CFG_W'(dv));
        write_reg(rgbk_pkg::REG_WIDTH, rgbk_pkg::CFG_W'(w));
        write_reg(rgbk_pkg::REG_HEIGHT, rgbk_pkg::CFG_W'(h));
    endtask

    // Hold until every pixel is sent and every result has come, then idle
    task automatic drain();
        do @(posedge aclk);
        while (pending_pixels.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic rgbk_pkg::pix_in_t rand_pixel();
        rgbk_pkg::pix_in_t p;
        p = rgbk_pkg::pix_in_t'($urandom);
        case ($urandom_range(7))
            0: p = '0;
            1: p = '1;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [rgbk_pkg::CFG_W-1:0] rand_kernel_row();
        logic [rgbk_pkg::CFG_W-1:0] v;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(3))
                0:       v[16*j +: 16] = 16'($urandom);
                1:       v[16*j +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                default: v[16*j +: 16] = 16'($signed($urandom_range(8)) - 4);
            endcase
        end
        return v;
    endfunction

    // Sender: hold valid and payload until the transfer, predict on transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                convolve_pixel(s_data);
                pixels_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_pixels.size() != 0 &&
                    $urandom_range(99) >= idle_send_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_pixels.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, check each result transfer
    always @(posedge aclk) begin
        rgbk_pkg::pix_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", m_data);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_data.red_out !== want.red_out ||
                        m_data.green_out !== want.green_out ||
                        m_data.blue_out !== want.blue_out ||
                        m_data.centre_row !== want.centre_row ||
                        m_data.centre_column !== want.centre_column ||
                        m_data.frame_done !== want.frame_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", want, m_data);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= idle_recv_pct);
        end
    end

    // Watchdog: end the run when transfers stop
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int w, h, n;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        m_ready       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        idle_send_pct = 12;
        idle_recv_pct = 47;
        mismatches    = 0;
        idle_cycles   = 0;
        pixels_sent   = 0;
        kern_top      = '0;
        kern_mid      = rgbk_pkg::CFG_W'(48'h10000);
        kern_bot      = '0;
        div_reg       = 1;
        width_reg     = 1024;
        height_reg    = 768;
        foreach (lines[k]) lines[k] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        col_pos = '0;
        row_pos = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Extreme kernel, zero divisor, sizes below range: one 3x3 frame
        write_all(48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 0, 0, 1);
        for (int k = 0; k < 9; k++)
            pending_pixels.push_back(k[0] ? rgbk_pkg::pix_in_t'('1)
                                          : rgbk_pkg::pix_in_t'('0));
        drain();
        // Largest divisor, then identity on a 4x3 frame of random pixels
        write_all(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 65535, 3, 3);
        for (int k = 0; k < 9; k++) pending_pixels.push_back(rgbk_pkg::pix_in_t'('1));
        drain();
        write_all(48'h0, 48'h1_0000, 48'h0, 1, 4, 3);
        for (int k = 0; k < 12; k++) pending_pixels.push_back(rand_pixel());
        drain();

        // Random phases; widths only grow at a frame start
        while (pixels_sent < RANDOM_PIXELS) begin
            if (pixels_sent > RANDOM_PIXELS / 3) begin
                idle_send_pct = 47;
                idle_recv_pct = 12;
            end
            if (pixels_sent > 2 * RANDOM_PIXELS / 3) begin
                idle_send_pct = 0;
                idle_recv_pct = 0;
            end
            if (pixels_sent > RANDOM_PIXELS / 2 && width_reg != 2047 &&
                col_pos == 0 && row_pos == 0) begin
                // Sizes above range: a wide frame, left unfinished
                write_all(rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                          $urandom_range(1, 16), 2047, 8191);
                n = 2 * rgbk_pkg::MAX_WIDTH + 40;
            end else begin
                w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
                if ((col_pos != 0 || row_pos != 0) && w > eff_width())
                    w = eff_width();
                h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
                write_all(rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                          $urandom_range(3) == 0 ? int'($urandom_range(65535))
                                                 : int'($urandom_range(16)), w, h);
                n = eff_width() * eff_height();
                n = $urandom_range(2) * n + $urandom_range(n);
            end
            for (int k = 0; k < n; k++) pending_pixels.push_back(rand_pixel());
            drain();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
